/* rtl/ascii_integer_parser_assert.svh */
// Assertion macros for the ASCII integer parser.
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AIP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define AIP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/aip_pkg.sv */
// Shared types and constants of the ASCII integer parser.
`timescale 1ns / 1ps

package aip_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIGNED_MODE  = 2'd0;
    localparam logic [1:0] CFG_HEX_DEFAULT  = 2'd1;
    localparam logic [1:0] CFG_RESULT_WIDTH = 2'd2;

    // Result width codes.
    localparam logic [1:0] RW_8  = 2'd0;
    localparam logic [1:0] RW_16 = 2'd1;
    localparam logic [1:0] RW_32 = 2'd2;
    localparam logic [1:0] RW_64 = 2'd3;

    // Status of the string in flight, as seen by the result stage.
    typedef struct packed {
        logic       negative;
        logic       error;
        logic       signed_mode;
        logic [1:0] result_width;
    } aip_status_t;

    typedef struct packed {
        logic [63:0] value;
        logic        ok;
    } aip_result_t;

endpackage

/* rtl/ascii_integer_parser.sv */
// Top level of the ASCII integer parser: string state, configuration and result register.
`timescale 1ns / 1ps
// The result of a string appears on the m_ side in the cycle after its NUL byte transfer.
// Throughput: one byte per cycle, with the next string starting right after the NUL byte.
// The only limit is the single result register, which stalls input while a result waits.
// Reset (aresetn low, synchronous) clears the string state and result valid, and loads
// signed_mode 0, hex_default 0 and result_width 3 (64 bits).
`include "ascii_integer_parser_assert.svh"

module ascii_integer_parser
    import aip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_ok,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    // ASCII codes the parser reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Where in the string the parser stands.
    typedef enum logic [1:0] {
        PH_SKIP,     // leading whitespace
        PH_ZERO,     // just after a leading '0'
        PH_AFTER_X,  // just after "0x"
        PH_DIGITS    // sign taken or digits running
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [63:0] acc_reg,    acc_next;
    logic        neg_reg,    neg_next;
    logic        hex_reg,    hex_next;
    logic        err_reg,    err_next;

    logic        signed_mode_reg,  signed_mode_next;
    logic        hex_default_reg,  hex_default_next;
    logic [1:0]  result_width_reg, result_width_next;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_value_reg, m_value_next;
    logic        m_ok_reg,    m_ok_next;

    logic        s_fire;
    logic        cfg_fire;
    logic        is_nul;
    logic        is_space;

    // Digit decode.
    logic [7:0]  folded;
    logic        digit_ok;
    logic [3:0]  digit_val;
    logic [63:0] acc_scaled;
    logic [63:0] acc_digit;

    aip_status_t status;
    aip_result_t result;

    // The result register frees up in the same cycle it is taken, so a new
    // byte is accepted whenever the register is empty or being drained.
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    assign is_nul   = (s_char_byte == CH_NUL);
    assign is_space = (s_char_byte == CH_SPACE) || (s_char_byte == CH_TAB) ||
                      (s_char_byte == CH_CR) || (s_char_byte == CH_LF) ||
                      (s_char_byte == CH_VT);

    // Letters are folded to lower case by setting the case bit. Decimal digits
    // already have it set, so their low nibble is the digit itself.
    assign folded = s_char_byte | CASE_BIT;

    always_comb begin
        digit_ok  = 1'b0;
        digit_val = 4'd0;
        if (s_char_byte < CH_ZERO || folded > CH_LO_F) begin
            digit_ok = 1'b0;
        end else if (folded <= CH_NINE) begin
            digit_ok  = 1'b1;
            digit_val = folded[3:0];
        end else if (folded >= CH_LO_A && hex_reg) begin
            digit_ok  = 1'b1;
            digit_val = folded[3:0] + 4'd9;
        end
    end

    // Multiply by the radix as shifts, with one add for radix ten; the sum wraps at 64 bits.
    assign acc_scaled = hex_reg ? {acc_reg[59:0], 4'b0000}
                                : {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};
    assign acc_digit  = acc_scaled + {60'd0, digit_val};

    // Next-state logic for the string, the configuration and the result register.
    always_comb begin
        phase_next        = phase_reg;
        acc_next          = acc_reg;
        neg_next          = neg_reg;
        hex_next          = hex_reg;
        err_next          = err_reg;
        signed_mode_next  = signed_mode_reg;
        hex_default_next  = hex_default_reg;
        result_width_next = result_width_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_value_next      = m_value_reg;
        m_ok_next         = m_ok_reg;

        if (s_fire) begin
            if (is_nul) begin
                // End of string: capture the result and start over.
                m_valid_next = 1'b1;
                m_value_next = result.value;
                m_ok_next    = result.ok;
                phase_next   = PH_SKIP;
                acc_next     = '0;
                neg_next     = 1'b0;
                hex_next     = hex_default_reg;
                err_next     = 1'b0;
            end else if (!err_reg) begin
                case (phase_reg)
                    PH_SKIP: begin
                        if (is_space) begin
                            phase_next = PH_SKIP;
                        end else if (s_char_byte < CH_SPACE) begin
                            err_next   = 1'b1;
                            phase_next = PH_DIGITS;
                        end else if (s_char_byte == CH_MINUS) begin
                            neg_next   = 1'b1;
                            phase_next = PH_DIGITS;
                        end else if (s_char_byte == CH_PLUS) begin
                            phase_next = PH_DIGITS;
                        end else if (s_char_byte == CH_ZERO) begin
                            phase_next = PH_ZERO;
                        end else begin
                            phase_next = PH_DIGITS;
                            if (digit_ok) acc_next = acc_digit;
                            else          err_next = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (s_char_byte == CH_LO_X || s_char_byte == CH_UP_X) begin
                            hex_next   = 1'b1;
                            phase_next = PH_AFTER_X;
                        end else if (s_char_byte == CH_PLUS) begin
                            phase_next = PH_DIGITS;
                        end else begin
                            phase_next = PH_DIGITS;
                            if (digit_ok) acc_next = acc_digit;
                            else          err_next = 1'b1;
                        end
                    end
                    PH_AFTER_X: begin
                        phase_next = PH_DIGITS;
                        if (s_char_byte != CH_PLUS) begin
                            if (digit_ok) acc_next = acc_digit;
                            else          err_next = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_DIGITS;
                        if (digit_ok) acc_next = acc_digit;
                        else          err_next = 1'b1;
                    end
                endcase
            end
        end

        // Configuration writes; an index past the list is ignored.
        if (cfg_fire) begin
            case (cfg_index)
                CFG_SIGNED_MODE: begin
                    signed_mode_next = cfg_data[0];
                end
                CFG_HEX_DEFAULT: begin
                    hex_default_next = cfg_data[0];
                    // The radix of a string already past its prefix stays put.
                    if (phase_reg == PH_SKIP) hex_next = cfg_data[0];
                end
                CFG_RESULT_WIDTH: begin
                    result_width_next = cfg_data;
                end
                default: begin
                    signed_mode_next = signed_mode_reg;
                end
            endcase
        end
    end

    assign status.negative     = neg_reg;
    assign status.error        = err_reg;
    assign status.signed_mode  = signed_mode_reg;
    assign status.result_width = result_width_reg;

    aip_finish u_finish (
        .acc    (acc_reg),
        .status (status),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SKIP;
            acc_reg          <= '0;
            neg_reg          <= 1'b0;
            hex_reg          <= 1'b0;
            err_reg          <= 1'b0;
            signed_mode_reg  <= 1'b0;
            hex_default_reg  <= 1'b0;
            result_width_reg <= RW_64;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            acc_reg          <= acc_next;
            neg_reg          <= neg_next;
            hex_reg          <= hex_next;
            err_reg          <= err_next;
            signed_mode_reg  <= signed_mode_next;
            hex_default_reg  <= hex_default_next;
            result_width_reg <= result_width_next;
            m_valid_reg      <= m_valid_next;
        end
        m_value_reg <= m_value_next;
        m_ok_reg    <= m_ok_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_ok    = m_ok_reg;

    // An error always moves the parser out of its prefix phases.
    `AIP_ASSERT_IMP(a_err_in_digits, err_reg, phase_reg == PH_DIGITS,
        "error flag set outside the digit phase")

    // A NUL transfer produces a result and leaves a clean string state.
    `AIP_ASSERT_NXT(a_nul_restarts, s_fire && is_nul,
        m_valid_reg && phase_reg == PH_SKIP && acc_reg == '0 && !err_reg && !neg_reg,
        "NUL transfer did not produce a result and clear the string state")

    // A failed parse always reports a zero value.
    `AIP_ASSERT_IMP(a_fail_is_zero, m_valid_reg && !m_ok_reg, m_value_reg == '0,
        "failed result carries a nonzero value")

endmodule

/* rtl/aip_finish.sv */
// Result stage: sign handling and saturation of the accumulated value.
`timescale 1ns / 1ps

module aip_finish
    import aip_pkg::*;
(
    input  logic [63:0] acc,
    input  aip_status_t status,
    output aip_result_t result
);

    logic        ok;
    logic [63:0] val;
    logic [63:0] umax;
    logic [63:0] shi;
    logic        clamp_on;

    // Largest unsigned value for the selected width.
    always_comb begin
        case (status.result_width)
            RW_8:    umax = 64'h0000_0000_0000_00FF;
            RW_16:   umax = 64'h0000_0000_0000_FFFF;
            RW_32:   umax = 64'h0000_0000_FFFF_FFFF;
            default: umax = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    end

    assign clamp_on = (status.result_width != RW_64);
    assign shi      = umax >> 1;
    assign ok       = !status.error && !(status.negative && !status.signed_mode);

    always_comb begin
        val = status.negative ? (64'd0 - acc) : acc;
        if (!ok) begin
            val = '0;
        end else if (status.signed_mode) begin
            // In range when all bits above the top magnitude bit equal the sign.
            if (clamp_on && ((val & ~shi) != 64'd0) && ((val & ~shi) != ~shi)) begin
                val = val[63] ? ~shi : shi;
            end
        end else begin
            if (clamp_on && ((val & ~umax) != 64'd0)) begin
                val = umax;
            end
        end
    end

    assign result.value = val;
    assign result.ok    = ok;

endmodule
